// File: src/ckp_pkg.sv
// ----------------------------------------------------------------------------
// ckp_pkg
// Shared types and constants of the keyword command line parser.
// ----------------------------------------------------------------------------
package ckp_pkg;

	localparam int MaxCommands = 16;
	localparam int MaxLength   = 32;
	localparam int IdW         = $clog2(MaxCommands);
	localparam int PosW        = $clog2(MaxLength);
	localparam int AddrW       = IdW + PosW;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic [1:0] STAT_KNOWN    = 2'd0;
	localparam logic [1:0] STAT_UNKNOWN  = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_FORMAT   = 2'd3;

	localparam logic [1:0] REG_COMMAND_COUNT = 2'd0;
	localparam logic [1:0] REG_BUFFER_LIMIT  = 2'd1;

	// scan request to the keyword unit
	typedef struct packed {
		logic            start;
		logic            decide;    // 0: narrow candidates, 1: pick first match
		logic            new_line;  // reload candidate mask with all ones
		logic [PosW-1:0] pos;
		logic            pos_full;  // keyword fills the whole entry
		logic [7:0]      ch;
		logic [IdW:0]    count;     // entries searched by decide
	} scan_req_t;

	// keyword table write
	typedef struct packed {
		logic             we;
		logic [AddrW-1:0] addr;
		logic [7:0]       data;
	} tab_wr_t;

	// scan response
	typedef struct packed {
		logic           done;
		logic           found;
		logic [IdW-1:0] id;
	} scan_rsp_t;

endpackage

// File: src/ckp_scan.sv
// ----------------------------------------------------------------------------
// ckp_scan
// Keyword table memory and sequential candidate scan over its entries.
// ----------------------------------------------------------------------------
module ckp_scan
	import ckp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  scan_req_t req,
	input  tab_wr_t   wr,
	output scan_rsp_t rsp
);

	logic [7:0]       tab_mem [MaxCommands*MaxLength];
	logic [AddrW-1:0] mem_addr;
	logic [7:0]       rd_data_s1;
	logic             rd_vld_s1;
	logic [IdW-1:0]   rd_idx_s1;

	logic             busy_q;
	logic             decide_q;
	logic [PosW-1:0]  pos_q;
	logic             full_q;
	logic [7:0]       ch_q;
	logic [IdW:0]     count_q;
	logic [IdW:0]     idx_q;
	logic [MaxCommands-1:0] mask_q;
	logic             found_q;
	logic [IdW-1:0]   id_q;
	logic             issue;
	logic             done;

	assign issue    = busy_q && !idx_q[IdW];
	assign done     = busy_q && idx_q[IdW] && !rd_vld_s1;
	assign mem_addr = wr.we ? wr.addr : {idx_q[IdW-1:0], pos_q};

	// single port table: write or registered read
	always_ff @(posedge clk) begin
		if (wr.we) begin
			tab_mem[mem_addr] <= wr.data;
		end
		if (issue) begin
			rd_data_s1 <= tab_mem[mem_addr];
		end
	end

	// scan sequencer: issue one entry a cycle, evaluate it in the cycle after issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			decide_q  <= 1'b0;
			pos_q     <= '0;
			full_q    <= 1'b0;
			ch_q      <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			mask_q    <= '1;
			found_q   <= 1'b0;
			id_q      <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
		end else begin
			rd_vld_s1 <= issue;
			rd_idx_s1 <= idx_q[IdW-1:0];
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (done) begin
				busy_q <= 1'b0;
			end
			if (rd_vld_s1) begin
				if (!decide_q) begin
					if (ch_q == CH_NUL || rd_data_s1 != ch_q) begin
						mask_q[rd_idx_s1] <= 1'b0;
					end
				end else if (!found_q && ({1'b0, rd_idx_s1} < count_q) &&
						mask_q[rd_idx_s1] && (full_q || rd_data_s1 == CH_NUL)) begin
					found_q <= 1'b1;
					id_q    <= rd_idx_s1;
				end
			end
			if (req.start) begin
				busy_q   <= 1'b1;
				decide_q <= req.decide;
				pos_q    <= req.pos;
				full_q   <= req.pos_full;
				ch_q     <= req.ch;
				count_q  <= req.count;
				idx_q    <= '0;
				found_q  <= 1'b0;
				id_q     <= '0;
				if (req.new_line) begin
					mask_q <= '1;
				end
			end
		end
	end

	assign rsp.done  = done;
	assign rsp.found = found_q;
	assign rsp.id    = id_q;

endmodule

// File: src/crlf_keyword_command_parser_core.sv
// ----------------------------------------------------------------------------
// crlf_keyword_command_parser_core
// Line parser for KEYWORD[=PARAMETER] CR LF commands with a keyword table.
// ----------------------------------------------------------------------------
// One character is taken per transaction. A keyword character, '=' and the
// CR that ends a keyword run a scan over all 16 keyword table entries through
// the table's single read port before the next transaction is taken. Other
// characters and table writes need no scan. After LF the status result is
// sent, then each parameter byte takes a parameter buffer read and then an
// output load, which waits until the consumer can take it.
module crlf_keyword_command_parser_core
	import ckp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // char_in, table_entry, table_pos, table_char
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // status, command_id, has_parameter,
	                                   // parameter_length, data_byte
	output logic        m_axis_tuser,  // byte_valid
	output logic        m_axis_tlast,  // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_KEY, ST_PAR, ST_LF} line_t;
	typedef enum logic [2:0] {PH_IN, PH_SCAN, PH_STAT, PH_RD, PH_LD} phase_t;

	line_t      line_q;
	phase_t     phase_q;
	logic [4:0] cnt_q;
	logic [5:0] blim_q;
	logic [5:0] fill_q;
	logic       hp_q;
	logic [1:0] pcode_q;
	logic [IdW-1:0] pid_q;
	logic [1:0] ost_q;
	logic [IdW-1:0] oid_q;
	logic       ohp_q;
	logic [5:0] olen_q;
	logic [PosW-1:0] k_q;
	logic       out_vld_q;
	logic [20:0] out_data_q;
	logic       out_bv_q;
	logic       out_last_q;

	logic [7:0] pbuf_mem [MaxLength];
	logic [7:0] pbuf_rd_s1;

	logic       acc;
	logic       kind;
	logic [7:0] ch;
	logic [5:0] lim;
	logic [4:0] cnt_eff;
	logic       out_free;
	logic       out_load;
	logic       par_we;
	scan_req_t  sreq;
	tab_wr_t    twr;
	scan_rsp_t  srsp;

	assign kind     = s_axis_tuser;
	assign ch       = s_axis_tdata[7:0];
	assign s_axis_tready = (phase_q == PH_IN);
	assign acc      = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign lim      = (blim_q > 6'(MaxLength)) ? 6'(MaxLength) : blim_q;
	assign cnt_eff  = (cnt_q > 5'(MaxCommands)) ? 5'(MaxCommands) : cnt_q;
	assign out_free = !out_vld_q || m_axis_tready;
	assign out_load = ((phase_q == PH_STAT) || (phase_q == PH_LD)) && out_free;
	assign par_we   = acc && !kind && line_q == ST_PAR && fill_q < lim && ch != CH_CR;

	// table write and scan request decode
	always_comb begin
		twr.we   = acc && kind && line_q == ST_IDLE;
		twr.addr = {s_axis_tdata[11:8], s_axis_tdata[16:12]};
		twr.data = s_axis_tdata[24:17];
		sreq.start    = 1'b0;
		sreq.decide   = 1'b0;
		sreq.new_line = 1'b0;
		sreq.pos      = fill_q[PosW-1:0];
		sreq.pos_full = fill_q[PosW];
		sreq.ch       = ch;
		sreq.count    = cnt_eff;
		if (acc && !kind) begin
			unique case (line_q)
				ST_IDLE: begin
					if (ch != CH_CR && ch != CH_LF) begin
						sreq.start    = 1'b1;
						sreq.new_line = 1'b1;
						sreq.pos      = '0;
						sreq.pos_full = 1'b0;
					end
				end
				ST_KEY: begin
					if (fill_q < lim) begin
						sreq.start  = 1'b1;
						sreq.decide = (ch == CH_CR) || (ch == CH_EQ);
					end
				end
				default: begin
				end
			endcase
		end
	end

	ckp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.wr     (twr),
		.rsp    (srsp)
	);

	// parameter buffer
	always_ff @(posedge clk) begin
		if (par_we) begin
			pbuf_mem[fill_q[PosW-1:0]] <= ch;
		end
		if (phase_q == PH_RD) begin
			pbuf_rd_s1 <= pbuf_mem[k_q];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			blim_q <= 6'd32;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COMMAND_COUNT: cnt_q  <= cfg_data[4:0];
				REG_BUFFER_LIMIT:  blim_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// line state, sequencing and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q     <= ST_IDLE;
			phase_q    <= PH_IN;
			fill_q     <= '0;
			hp_q       <= 1'b0;
			pcode_q    <= '0;
			pid_q      <= '0;
			ost_q      <= '0;
			oid_q      <= '0;
			ohp_q      <= 1'b0;
			olen_q     <= '0;
			k_q        <= '0;
			out_vld_q  <= 1'b0;
			out_data_q <= '0;
			out_bv_q   <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (out_vld_q && m_axis_tready && !out_load) begin
				out_vld_q <= 1'b0;
			end
			unique case (phase_q)
				PH_IN: begin
					if (acc && !kind) begin
						unique case (line_q)
							ST_IDLE: begin
								if (ch != CH_CR && ch != CH_LF) begin
									fill_q  <= 6'd1;
									hp_q    <= 1'b0;
									pcode_q <= STAT_KNOWN;
									pid_q   <= '0;
									line_q  <= ST_KEY;
									phase_q <= PH_SCAN;
								end
							end
							ST_KEY, ST_PAR: begin
								if (fill_q >= lim) begin
									line_q  <= ST_IDLE;
									fill_q  <= '0;
									hp_q    <= 1'b0;
									ost_q   <= STAT_OVERFLOW;
									oid_q   <= '0;
									ohp_q   <= 1'b0;
									olen_q  <= '0;
									phase_q <= PH_STAT;
								end else if (ch == CH_CR) begin
									line_q <= ST_LF;
									if (line_q == ST_KEY) begin
										phase_q <= PH_SCAN;
									end
								end else if (ch == CH_EQ && line_q == ST_KEY) begin
									line_q  <= ST_PAR;
									fill_q  <= '0;
									hp_q    <= 1'b1;
									phase_q <= PH_SCAN;
								end else begin
									fill_q <= fill_q + 1'b1;
									if (line_q == ST_KEY) begin
										phase_q <= PH_SCAN;
									end
								end
							end
							ST_LF: begin
								line_q <= ST_IDLE;
								ost_q  <= (ch != CH_LF) ? STAT_FORMAT : pcode_q;
								oid_q  <= (ch == CH_LF && pcode_q == STAT_KNOWN) ?
									pid_q : '0;
								ohp_q  <= hp_q;
								olen_q <= hp_q ? fill_q : '0;
								phase_q <= PH_STAT;
							end
							default: begin
							end
						endcase
					end
				end
				PH_SCAN: begin
					if (srsp.done) begin
						phase_q <= PH_IN;
						// decide results land after '=' or CR
						if (line_q == ST_PAR || line_q == ST_LF) begin
							pcode_q <= srsp.found ? STAT_KNOWN : STAT_UNKNOWN;
							pid_q   <= srsp.found ? srsp.id : '0;
						end
					end
				end
				PH_STAT: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_data_q <= {8'd0, olen_q, ohp_q, oid_q, ost_q};
						out_bv_q   <= 1'b0;
						out_last_q <= (olen_q == '0);
						k_q        <= '0;
						phase_q    <= (olen_q == '0) ? PH_IN : PH_RD;
					end
				end
				PH_RD: begin
					phase_q <= PH_LD;
				end
				PH_LD: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_data_q <= {pbuf_rd_s1, olen_q, ohp_q, oid_q, ost_q};
						out_bv_q   <= 1'b1;
						out_last_q <= ({1'b0, k_q} + 6'd1 == olen_q);
						if ({1'b0, k_q} + 6'd1 == olen_q) begin
							phase_q <= PH_IN;
						end else begin
							k_q     <= k_q + 1'b1;
							phase_q <= PH_RD;
						end
					end
				end
				default: begin
					phase_q <= PH_IN;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'd0, out_data_q};
	assign m_axis_tuser  = out_bv_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// File: src/ckp_checker.sv
// ----------------------------------------------------------------------------
// ckp_checker
// Port-level checks of the command parser result stream.
// ----------------------------------------------------------------------------
module ckp_checker
	import ckp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// overflow is a single-item run
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == STAT_OVERFLOW |->
			m_axis_tlast && !m_axis_tuser && m_axis_tdata[12:7] == 6'd0)
		else $error("overflow result malformed");

	// status item without parameter ends the run
	a_nolen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && m_axis_tdata[12:7] == 6'd0 |-> m_axis_tlast)
		else $error("empty run not marked last");

	// byte items only come with a parameter
	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[6] && m_axis_tdata[12:7] != 6'd0)
		else $error("parameter byte without parameter");

endmodule

bind crlf_keyword_command_parser_core ckp_checker u_ckp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_crlf_keyword_command_parser_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crlf_keyword_command_parser_core
// Self-checking bench for the CR LF keyword command line parser.
// Characters and keyword table writes go in on the input stream. A behavioral
// model of the parser builds the expected status and parameter byte results,
// which are checked field by field against the output stream. The run walks
// through several settings of the entry count and the buffer limit.
// ----------------------------------------------------------------------------
module tb_crlf_keyword_command_parser_core;
	import ckp_pkg::*;

	localparam int CycleLimit   = 1000000;
	localparam int TabPositions = 7;

	// expected line result
	typedef struct packed {
		bit [1:0] status;
		bit [3:0] id;
		bit       has_par;
		bit [5:0] par_len;
		bit [7:0] data;
		bit       byte_valid;
		bit       last;
	} line_res_t;

	typedef enum int {PS_IDLE, PS_KEY, PS_PAR, PS_LF} parse_state_t;

	// ------------------------------------------------------------------------
	// parser model and store of pending line results
	// ------------------------------------------------------------------------
	class ckp_scoreboard;
		bit [7:0]     kw_mem[MaxCommands*MaxLength];
		bit [7:0]     par_mem[MaxLength];
		parse_state_t pstate;
		int           fill;
		bit           has_par;
		bit [1:0]     code;
		bit [3:0]     id;
		bit [15:0]    mask;
		int           entry_count;
		int           limit_reg;
		line_res_t    pending_q[$];
		int           errors;
		int           results_seen;
		int           lines_done;

		function void reset_state();
			pstate = PS_IDLE;
			fill = 0;
			has_par = 0;
			code = STAT_KNOWN;
			id = 0;
			mask = '1;
			entry_count = 0;
			limit_reg = 32;
		endfunction

		function void configure(bit [1:0] index, bit [5:0] value);
			if (index == REG_COMMAND_COUNT)
				entry_count = value[4:0];
			else if (index == REG_BUFFER_LIMIT)
				limit_reg = value;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function void narrow(int p, bit [7:0] c);
			for (int i = 0; i < MaxCommands; i++) begin
				if (c == CH_NUL || kw_mem[i*MaxLength+p] != c)
					mask[i] = 0;
			end
		endfunction

		// first candidate whose keyword ends at the current position wins
		function void decide();
			int n;
			n = entry_count > MaxCommands ? MaxCommands : entry_count;
			code = STAT_UNKNOWN;
			id = 0;
			for (int i = 0; i < n; i++) begin
				if (!mask[i]) continue;
				if (fill < MaxLength && kw_mem[i*MaxLength+fill] != 0) continue;
				code = STAT_KNOWN;
				id = 4'(i);
				break;
			end
		endfunction

		function void push(bit [1:0] st, bit [3:0] cid, bit hp, bit [5:0] len,
				bit [7:0] b, bit bv, bit lst);
			line_res_t r;
			r.status = st;
			r.id = cid;
			r.has_par = hp;
			r.par_len = len;
			r.data = b;
			r.byte_valid = bv;
			r.last = lst;
			pending_q.push_back(r);
		endfunction

		// one accepted input transaction
		function void note_input(bit kind, bit [31:0] d);
			bit [7:0] c;
			int lim;
			int len;
			bit [3:0] rid;
			c = d[7:0];
			lim = limit_reg > MaxLength ? MaxLength : limit_reg;
			if (kind) begin
				if (pstate == PS_IDLE)
					kw_mem[{d[11:8], d[16:12]}] = d[24:17];
				return;
			end
			case (pstate)
				PS_IDLE: begin
					if (c != CH_CR && c != CH_LF) begin
						mask = '1;
						narrow(0, c);
						fill = 1;
						has_par = 0;
						code = STAT_KNOWN;
						id = 0;
						pstate = PS_KEY;
					end
				end
				PS_KEY, PS_PAR: begin
					if (fill >= lim) begin
						pstate = PS_IDLE;
						fill = 0;
						has_par = 0;
						push(STAT_OVERFLOW, 0, 0, 0, 0, 0, 1);
						lines_done++;
					end else if (c == CH_CR) begin
						if (pstate == PS_KEY) decide();
						pstate = PS_LF;
					end else if (c == CH_EQ && pstate == PS_KEY) begin
						decide();
						pstate = PS_PAR;
						fill = 0;
						has_par = 1;
					end else begin
						if (pstate == PS_KEY) narrow(fill, c);
						else par_mem[fill] = c;
						fill++;
					end
				end
				default: begin
					if (c != CH_LF) code = STAT_FORMAT;
					pstate = PS_IDLE;
					len = has_par ? fill : 0;
					rid = code == STAT_KNOWN ? id : 4'd0;
					push(code, rid, has_par, 6'(len), 0, 0, len == 0);
					for (int i = 0; i < len; i++)
						push(code, rid, has_par, 6'(len), par_mem[i], 1, i + 1 == len);
					lines_done++;
				end
			endcase
		endfunction

		// one accepted output transaction
		function void check_result(bit [23:0] d, bit bv, bit lst);
			line_res_t x;
			results_seen++;
			if (pending_q.size() == 0) begin
				$error("unexpected result tdata=%h tuser=%0d tlast=%0d", d, bv, lst);
				errors++;
				return;
			end
			x = pending_q.pop_front();
			if (d[1:0] != x.status) begin
				$error("status: expected %0d, got %0d", x.status, d[1:0]);
				errors++;
			end
			if (d[5:2] != x.id) begin
				$error("command_id: expected %0d, got %0d", x.id, d[5:2]);
				errors++;
			end
			if (d[6] != x.has_par) begin
				$error("has_parameter: expected %0d, got %0d", x.has_par, d[6]);
				errors++;
			end
			if (d[12:7] != x.par_len) begin
				$error("parameter_length: expected %0d, got %0d", x.par_len, d[12:7]);
				errors++;
			end
			if (d[20:13] != x.data) begin
				$error("data_byte: expected %h, got %h", x.data, d[20:13]);
				errors++;
			end
			if (bv != x.byte_valid) begin
				$error("byte_valid: expected %0d, got %0d", x.byte_valid, bv);
				errors++;
			end
			if (lst != x.last) begin
				$error("last: expected %0d, got %0d", x.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // char_in, table_entry, table_pos, table_char
	logic        s_axis_tuser;   // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // status, command_id, has_parameter,
	                             // parameter_length, data_byte
	logic        m_axis_tuser;   // byte_valid
	logic        m_axis_tlast;   // last
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [5:0]  cfg_data;

	ckp_scoreboard sb;
	int            cycle_cnt;
	int            burst_left;
	int            rand_items;
	string         kw_name[MaxCommands];

	crlf_keyword_command_parser_core DUT (.*);

	// clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// receiver: accept check plus a shifting stall pattern
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("[crlf_keyword_command_parser_core] ERROR");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		case ((cycle_cnt / 300) % 4)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 99) < 70;
			2: m_axis_tready <= $urandom_range(0, 99) < 25;
			default: m_axis_tready <= (cycle_cnt % 16) > 5;
		endcase
	end

	// one input transaction, sent in bursts with random gaps
	task automatic send_item(bit kind, bit [31:0] d);
		if (burst_left == 0) begin
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(kind, d);
		burst_left--;
	endtask

	task automatic send_char(bit [7:0] c);
		send_item(1'b0, {24'd0, c});
	endtask

	task automatic write_table(bit [3:0] e, bit [4:0] p, bit [7:0] c);
		send_item(1'b1, {7'd0, c, p, e, 8'($urandom_range(0, 255))});
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_char(s[i]);
	endtask

	// close any open line, let results drain and the scan finish
	task automatic drain();
		while (sb.pstate != PS_IDLE)
			send_char(sb.pstate == PS_LF ? CH_LF : CH_CR);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(bit [1:0] index, bit [5:0] value);
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.configure(index, value);
	endtask

	// keywords sent never exceed six characters, so only the first
	// TabPositions bytes of each entry are ever read; those all get a value
	task automatic load_table();
		string s;
		for (int e = 0; e < MaxCommands; e++) begin
			case (e)
				0: s = "GO";
				1: s = "SET";
				2: s = "RUN";
				3: s = "SET";       // duplicate: entry 1 must win
				15: s = "ZZZZZZ";   // longest keyword in use
				default: begin
					s = "";
					repeat ($urandom_range(1, 4)) s = {s, string'(8'("A" + $urandom_range(0, 2)))};
				end
			endcase
			kw_name[e] = s;
			for (int p = 0; p < TabPositions; p++) begin
				if (p < s.len()) write_table(4'(e), 5'(p), s[p]);
				else if (p == s.len()) write_table(4'(e), 5'(p), CH_NUL);
				else write_table(4'(e), 5'(p), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// random line: mostly well-formed, some noise and broken endings
	task automatic random_line();
		int kind_sel;
		int lim;
		string s;
		kind_sel = $urandom_range(0, 99);
		lim = sb.limit_reg > MaxLength ? MaxLength : sb.limit_reg;
		if (kind_sel < 12) begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 3) == 0)
					write_table(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
						8'($urandom_range(0, 255)));
				else
					send_char(8'($urandom_range(0, 255)));
				rand_items++;
			end
			// close the noise so keywords stay short
			send_text("\r\n");
			rand_items += 2;
			return;
		end
		if (kind_sel < 70)
			s = kw_name[$urandom_range(0, MaxCommands - 1)];
		else begin
			s = "";
			repeat ($urandom_range(1, 6)) s = {s, string'(8'("A" + $urandom_range(0, 3)))};
		end
		if ($urandom_range(0, 9) == 0 && s.len() > 0) s = s.substr(0, s.len() - 2);
		if (s.len() == 0) s = "A";
		if ($urandom_range(0, 1)) begin
			s = {s, "="};
			repeat ($urandom_range(0, $urandom_range(0, 3) == 0 ? lim + 1 : 6)) begin
				bit [7:0] b;
				b = 8'($urandom_range(0, 255));
				if (b == CH_CR) b = CH_EQ;
				s = {s, string'(b)};
			end
		end
		if ($urandom_range(0, 15) == 0) begin
			// table write during the line, dropped by the parser
			send_text(s);
			write_table(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
				8'($urandom_range(0, 255)));
			s = "";
		end
		s = {s, "\r"};
		s = {s, string'($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : CH_LF)};
		rand_items += s.len();
		send_text(s);
	endtask

	initial begin
		int settings[8][2];
		sb = new();
		sb.reset_state();
		cycle_cnt     = 0;
		burst_left    = 0;
		rand_items    = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_table();
		write_reg(REG_COMMAND_COUNT, 6'd16);
		write_reg(REG_BUFFER_LIMIT, 6'd32);

		// directed lines
		send_text("\r\nGO\r\n");               // idle CR LF skipped, known
		send_text("SET=ab=c\r\n");             // duplicate keyword, '=' in parameter
		send_text("=X\r\n");                   // leading '=' is a keyword char
		send_text("RUN=\r\n");                 // empty parameter
		send_text("GOX\rQ");                   // unknown, then format error
		send_char(8'hFF);
		send_char(CH_NUL);                     // NUL inside keyword
		send_text("\r\n");
		send_text({"SET=", {33{"p"}}});        // parameter overflow
		drain();
		write_reg(REG_BUFFER_LIMIT, 6'd4);
		send_text("ZZZZZ");                    // keyword overflow
		drain();

		// settings sweep, extremes included
		settings = '{'{0, 32}, '{16, 1}, '{31, 63}, '{5, 8}, '{16, 0},
			'{12, 20}, '{1, 4}, '{16, 32}};
		foreach (settings[k]) begin
			write_reg(REG_COMMAND_COUNT, 6'(settings[k][0]));
			write_reg(REG_BUFFER_LIMIT, 6'(settings[k][1]));
			while (rand_items < (k + 1) * 16)
				random_line();
			drain();
		end

		$display("Covered %0d lines and %0d results over %0d register settings.",
			sb.lines_done, sb.results_seen, 9);
		if (sb.errors == 0)
			$display("[crlf_keyword_command_parser_core] OK");
		else
			$display("[crlf_keyword_command_parser_core] ERROR");
		$finish;
	end

endmodule
